@@ rtl/array_linked_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the array linked list engine
// Short forms for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ALLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ALLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/alle_pkg.sv @@
// ----------------------------------------------------------------------------
// alle_pkg
// Codes, widths and controller/datapath handshake types of the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alle_pkg;

   localparam int MODE_W      = 2;
   localparam int POS_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int SLOT_W      = 4;
   localparam int CNT_W       = 4;
   localparam int MAX_RESULTS = 14;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_DUMP   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BEYOND = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // link memory read address source
   typedef enum logic [1:0] {
      RA_ZERO = 2'd0,
      RA_HEAD = 2'd1,
      RA_LINK = 2'd2,
      RA_CUR  = 2'd3
   } rd_addr_type;

   // link memory write address source
   typedef enum logic [1:0] {
      WA_ZERO = 2'd0,
      WA_CUR  = 2'd1,
      WA_J    = 2'd2
   } wr_addr_type;

   // link memory write data source
   typedef enum logic [1:0] {
      WD_LINK = 2'd0,
      WD_LJ   = 2'd1,
      WD_CUR  = 2'd2
   } wr_data_type;

   typedef struct packed {
      logic        latch;
      rd_addr_type rd_addr;
      logic        wr_en;
      wr_addr_type wr_addr;
      wr_data_type wr_data;
      logic        val_we;
      logic        j_head;
      logic        j_step;
      logic        cur_load;
      logic        lj_load;
      logic        cnt_clr;
      logic        cnt_inc;
      logic        emit;
      status_type  emit_status;
      logic        emit_dump;
      logic        emit_last;
   } cmd_type;

   typedef struct packed {
      logic link_zero;
      logic link_full;
      logic walk_done;
      logic dump_final;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/alle_dpath.sv @@
// ----------------------------------------------------------------------------
// alle_dpath
// Link and value memories, walk pointers, step counter and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_linked_list_engine_assert.svh"

module alle_dpath #(
   parameter int SLOTS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire alle_pkg::cmd_type                    cmd,
   output alle_pkg::sts_type                         sts,
   input  wire logic [alle_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [alle_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_strobe,
   output logic [alle_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [alle_pkg::VALUE_W-1:0]       rsp_value_res,
   output logic [alle_pkg::SLOT_W-1:0]               rsp_slot,
   output logic                                      rsp_last
);

   localparam int LinkW = $clog2(SLOTS);
   localparam int SlotW = alle_pkg::SLOT_W;
   localparam int CntW  = alle_pkg::CNT_W;
   localparam logic [LinkW-1:0] HeadSlot = LinkW'(SLOTS - 1);
   localparam logic [CntW-1:0]  LastCnt  = CntW'(alle_pkg::MAX_RESULTS - 1);

   // link value a slot holds straight after reset
   function automatic logic [LinkW-1:0] reset_link(input logic [LinkW-1:0] a);
      if (int'(a) + 2 < SLOTS)
         reset_link = a + 1'b1;
      else
         reset_link = '0;
   endfunction

   logic [LinkW-1:0]                   link_mem [SLOTS];
   logic [alle_pkg::VALUE_W-1:0]       val_mem  [SLOTS];
   logic [SLOTS-1:0]                   valid_ff;

   logic [LinkW-1:0]                   rd_addr;
   logic [LinkW-1:0]                   wr_addr;
   logic [LinkW-1:0]                   wr_data;
   logic [LinkW-1:0]                   link_mem_ff;
   logic [LinkW-1:0]                   link_rst_ff;
   logic                               link_vld_ff;
   logic [LinkW-1:0]                   link_rd;
   logic [alle_pkg::VALUE_W-1:0]       val_rd_ff;

   logic [alle_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic signed [alle_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [LinkW-1:0]                   j_ff, j_in;
   logic [LinkW-1:0]                   cur_ff, cur_in;
   logic [LinkW-1:0]                   lj_ff, lj_in;
   logic [CntW-1:0]                    cnt_ff, cnt_in;

   logic                               rsp_strobe_ff;
   alle_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic signed [alle_pkg::VALUE_W-1:0] rsp_value_res_ff, rsp_value_res_in;
   logic [SlotW-1:0]                   rsp_slot_ff, rsp_slot_in;
   logic                               rsp_last_ff, rsp_last_in;

   // entries never written read as their reset link
   assign link_rd = link_vld_ff ? link_mem_ff : link_rst_ff;

   always_comb begin
      unique case (cmd.rd_addr)
         alle_pkg::RA_ZERO: rd_addr = '0;
         alle_pkg::RA_HEAD: rd_addr = HeadSlot;
         alle_pkg::RA_LINK: rd_addr = link_rd;
         alle_pkg::RA_CUR:  rd_addr = cur_ff;
         default:           rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_addr)
         alle_pkg::WA_ZERO: wr_addr = '0;
         alle_pkg::WA_CUR:  wr_addr = cur_ff;
         alle_pkg::WA_J:    wr_addr = j_ff;
         default:           wr_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_data)
         alle_pkg::WD_LINK: wr_data = link_rd;
         alle_pkg::WD_LJ:   wr_data = lj_ff;
         alle_pkg::WD_CUR:  wr_data = cur_ff;
         default:           wr_data = '0;
      endcase
   end

   // link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      link_mem_ff <= link_mem[rd_addr];
      link_rst_ff <= reset_link(rd_addr);
      link_vld_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // value memory: written on insert, read during a dump
   always_ff @(posedge clock) begin
      if (cmd.val_we) begin
         val_mem[cur_ff] <= val_ff;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

   always_comb begin
      pos_in = pos_ff;
      val_in = val_ff;
      if (cmd.latch) begin
         pos_in = (req_position == '0) ? '0 : req_position - 1'b1;
         val_in = req_value;
      end

      j_in = j_ff;
      if (cmd.j_head)
         j_in = HeadSlot;
      else if (cmd.j_step)
         j_in = link_rd;

      cur_in = cmd.cur_load ? link_rd : cur_ff;
      lj_in  = cmd.lj_load  ? link_rd : lj_ff;

      cnt_in = cnt_ff;
      if (cmd.cnt_clr)
         cnt_in = '0;
      else if (cmd.cnt_inc)
         cnt_in = cnt_ff + 1'b1;

      rsp_status_in    = cmd.emit_status;
      rsp_value_res_in = cmd.emit_dump ? val_rd_ff : '0;
      rsp_slot_in      = (cmd.emit_status == alle_pkg::ST_OK) ? SlotW'(cur_ff) : '0;
      rsp_last_in      = cmd.emit_last;
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
      lj_ff  <= lj_in;
      cnt_ff <= cnt_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_value_res_ff <= rsp_value_res_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   assign sts.link_zero  = (link_rd == '0);
   assign sts.link_full  = (link_rd == '0) || (link_rd == HeadSlot);
   assign sts.walk_done  = (cnt_ff == pos_ff);
   assign sts.dump_final = (link_rd == '0) || (cnt_ff == LastCnt);

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_res = rsp_value_res_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_last      = rsp_last_ff;

   `ALLE_ASSERT_SAME(a_free_head_not_list, clock, reset, cmd.wr_en && cmd.wr_addr == alle_pkg::WA_ZERO, wr_data != HeadSlot, "free chain would point at the list head")
   `ALLE_ASSERT_SAME(a_ok_slot_is_node, clock, reset, cmd.emit && cmd.emit_status == alle_pkg::ST_OK, cur_ff != '0 && cur_ff != HeadSlot, "ok beat names a chain head slot")
   `ALLE_ASSERT_NEXT(a_fail_beat_clean, clock, reset, cmd.emit && cmd.emit_status != alle_pkg::ST_OK, rsp_strobe && rsp_slot == '0 && rsp_value_res == '0, "failed beat carries payload")

endmodule

`default_nettype wire

@@ rtl/alle_ctrl.sv @@
// ----------------------------------------------------------------------------
// alle_ctrl
// Sequencer for insert, delete and dump: one link hop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_linked_list_engine_assert.svh"

module alle_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [alle_pkg::MODE_W-1:0]    req_mode,
   input  wire alle_pkg::sts_type              sts,
   output logic                                busy,
   output alle_pkg::cmd_type                   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_I_FREE,
      ST_I_WALK,
      ST_I_RDC,
      ST_I_WCUR,
      ST_I_WJ,
      ST_D_CHK,
      ST_D_WALK,
      ST_D_RDC,
      ST_D_RD0,
      ST_D_W0,
      ST_P_CHK,
      ST_P_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit_last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch   = 1'b1;
               cmd.rd_addr = alle_pkg::RA_HEAD;
               unique case (req_mode)
                  alle_pkg::MODE_INSERT: begin
                     cmd.rd_addr = alle_pkg::RA_ZERO;
                     state_in    = ST_I_FREE;
                  end
                  alle_pkg::MODE_DELETE: state_in = ST_D_CHK;
                  alle_pkg::MODE_DUMP:   state_in = ST_P_CHK;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end

         // free head in hand: drop on full, else start the walk from the list head
         ST_I_FREE: begin
            if (sts.link_full) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = alle_pkg::ST_FULL;
               state_in        = ST_IDLE;
            end else begin
               cmd.cur_load = 1'b1;
               cmd.rd_addr  = alle_pkg::RA_HEAD;
               cmd.j_head   = 1'b1;
               cmd.cnt_clr  = 1'b1;
               state_in     = ST_I_WALK;
            end
         end

         ST_I_WALK: begin
            if (sts.walk_done) begin
               cmd.lj_load = 1'b1;
               cmd.rd_addr = alle_pkg::RA_CUR;
               state_in    = ST_I_RDC;
            end else if (sts.link_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = alle_pkg::ST_BEYOND;
               state_in        = ST_IDLE;
            end else begin
               cmd.j_step  = 1'b1;
               cmd.rd_addr = alle_pkg::RA_LINK;
               cmd.cnt_inc = 1'b1;
            end
         end

         // pop the free chain and store the value
         ST_I_RDC: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = alle_pkg::WA_ZERO;
            cmd.wr_data = alle_pkg::WD_LINK;
            cmd.val_we  = 1'b1;
            state_in    = ST_I_WCUR;
         end

         ST_I_WCUR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = alle_pkg::WA_CUR;
            cmd.wr_data = alle_pkg::WD_LJ;
            state_in    = ST_I_WJ;
         end

         ST_I_WJ: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr     = alle_pkg::WA_J;
            cmd.wr_data     = alle_pkg::WD_CUR;
            cmd.emit        = 1'b1;
            cmd.emit_status = alle_pkg::ST_OK;
            state_in        = ST_IDLE;
         end

         ST_D_CHK: begin
            if (sts.link_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = alle_pkg::ST_EMPTY;
               state_in        = ST_IDLE;
            end else begin
               cmd.rd_addr = alle_pkg::RA_HEAD;
               cmd.j_head  = 1'b1;
               cmd.cnt_clr = 1'b1;
               state_in    = ST_D_WALK;
            end
         end

         ST_D_WALK: begin
            if (sts.link_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = alle_pkg::ST_BEYOND;
               state_in        = ST_IDLE;
            end else if (sts.walk_done) begin
               cmd.cur_load = 1'b1;
               cmd.rd_addr  = alle_pkg::RA_LINK;
               state_in     = ST_D_RDC;
            end else begin
               cmd.j_step  = 1'b1;
               cmd.rd_addr = alle_pkg::RA_LINK;
               cmd.cnt_inc = 1'b1;
            end
         end

         // unlink the node, then push it on the free chain
         ST_D_RDC: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = alle_pkg::WA_J;
            cmd.wr_data = alle_pkg::WD_LINK;
            cmd.rd_addr = alle_pkg::RA_ZERO;
            state_in    = ST_D_RD0;
         end

         ST_D_RD0: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = alle_pkg::WA_CUR;
            cmd.wr_data = alle_pkg::WD_LINK;
            state_in    = ST_D_W0;
         end

         ST_D_W0: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr     = alle_pkg::WA_ZERO;
            cmd.wr_data     = alle_pkg::WD_CUR;
            cmd.emit        = 1'b1;
            cmd.emit_status = alle_pkg::ST_OK;
            state_in        = ST_IDLE;
         end

         ST_P_CHK: begin
            if (sts.link_zero) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = alle_pkg::ST_EMPTY;
               state_in        = ST_IDLE;
            end else begin
               cmd.cur_load = 1'b1;
               cmd.rd_addr  = alle_pkg::RA_LINK;
               cmd.cnt_clr  = 1'b1;
               state_in     = ST_P_OUT;
            end
         end

         // one element beat per cycle; advance along the list
         ST_P_OUT: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = alle_pkg::ST_OK;
            cmd.emit_dump   = 1'b1;
            cmd.emit_last   = sts.dump_final;
            if (sts.dump_final) begin
               state_in = ST_IDLE;
            end else begin
               cmd.cur_load = 1'b1;
               cmd.rd_addr  = alle_pkg::RA_LINK;
               cmd.cnt_inc  = 1'b1;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   `ALLE_ASSERT_SAME(a_busy_tracks_state, clock, reset, 1'b1, busy_ff == (state_ff != ST_IDLE), "busy out of step with state")
   `ALLE_ASSERT_SAME(a_no_write_idle, clock, reset, cmd.wr_en || cmd.val_we || cmd.emit, state_ff != ST_IDLE, "store touched or beat formed while idle")
   `ALLE_ASSERT_NEXT(a_unused_mode_ignored, clock, reset, accept && req_mode != alle_pkg::MODE_INSERT && req_mode != alle_pkg::MODE_DELETE && req_mode != alle_pkg::MODE_DUMP, !busy_ff, "unused mode started work")

endmodule

`default_nettype wire

@@ rtl/array_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Ordered list of 32-bit values in a fixed slot store with a free-slot chain.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_mode/req_position/req_value with start high;
//   the command is taken at an edge where busy is low. Mode 0 inserts value
//   as element number position, mode 1 deletes element number position,
//   mode 2 dumps the list in order; mode 3 is taken and dropped.
//   Result channel: each beat sits on rsp_* for exactly one cycle, marked by
//   rsp_strobe; rsp_last flags the final beat of a command. The receiver
//   cannot stall, so beats are never held back.
//   Timing: the link memory has one read port and the walk makes one hop per
//   cycle. Position 0 acts as position 1. A dump gives at most 14 elements.
//   Each beat is registered and appears in the cycle after it is formed:
//   busy drops in the cycle the final beat is on rsp_*, and the next command
//   can be taken at the edge that ends it. A position past the end fails, as
//   do an insert into a full store and a delete on an empty list.
//   Reset: synchronous; clears the link valid bits so every slot reads its
//   power-on link (free chain 1..SLOTS-2, empty list) with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_engine #(
   parameter int SLOTS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [alle_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [alle_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [alle_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_strobe,
   output logic [alle_pkg::STATUS_W-1:0]             rsp_status,
   output logic signed [alle_pkg::VALUE_W-1:0]       rsp_value_res,
   output logic [alle_pkg::SLOT_W-1:0]               rsp_slot,
   output logic                                      rsp_last
);

   // command and status bundles between sequencer and datapath
   alle_pkg::cmd_type cmd;
   alle_pkg::sts_type sts;

   // sequencer: decodes the command, steps the walk, schedules memory writes
   alle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   // datapath: link/value memories, walk pointers and the result beat register
   alle_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value_res (rsp_value_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

@@ tb/list_engine_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_engine_checker
// Watches the command and result channels of the linked list engine, keeps
// a shadow copy of the slot store and checks every result beat in order.
// ----------------------------------------------------------------------------
module list_engine_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic                                 busy,
   input  wire logic [alle_pkg::MODE_W-1:0]          req_mode,
   input  wire logic [alle_pkg::POS_W-1:0]           req_position,
   input  wire logic signed [alle_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                                 rsp_strobe,
   input  wire logic [alle_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic signed [alle_pkg::VALUE_W-1:0]  rsp_value_res,
   input  wire logic [alle_pkg::SLOT_W-1:0]          rsp_slot,
   input  wire logic                                 rsp_last,
   output int                                        mismatch_count,
   output int                                        pending_beats
);
   import alle_pkg::*;

   localparam int SLOTS     = 16;
   localparam int LIST_HEAD = SLOTS - 1;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  value;
      logic [SLOT_W-1:0]          slot;
      logic                       last;
   } beat_type;

   logic [SLOT_W-1:0]          link_mem  [SLOTS];
   logic signed [VALUE_W-1:0]  value_mem [SLOTS];
   beat_type                   expected_beats [$];
   beat_type                   want;

   initial begin
      mismatch_count = 0;
      pending_beats  = 0;
   end

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("checker: %s mismatch, got %0h expected %0h at %0t", what, got, exp, $time);
      mismatch_count++;
   endtask

   function automatic beat_type make_beat(input status_type st,
                                          input logic signed [VALUE_W-1:0] val,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic last);
      beat_type b;
      b.status = st;
      b.value  = val;
      b.slot   = slot;
      b.last   = last;
      return b;
   endfunction

   // free chain 1..SLOTS-2 off slot 0, empty list off the head slot
   task reset_store;
      for (int i = 0; i < SLOTS; i++) begin
         link_mem[i]  = (i < SLOTS - 2) ? SLOT_W'(i + 1) : '0;
         value_mem[i] = '0;
      end
      expected_beats.delete();
   endtask

   task apply_list_command(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                           input logic signed [VALUE_W-1:0] val);
      logic [SLOT_W-1:0] walk;
      logic [SLOT_W-1:0] cur;
      logic [SLOT_W-1:0] nxt;
      int                steps;
      int                n;
      steps = (pos == 0) ? 1 : int'(pos);
      case (mode)
         MODE_INSERT: begin
            cur = link_mem[0];
            if (cur == 0 || cur >= LIST_HEAD) begin
               expected_beats.push_back(make_beat(ST_FULL, '0, '0, 1'b1));
            end else begin
               walk = SLOT_W'(LIST_HEAD);
               for (int k = 1; k < steps && walk != 0; k++)
                  walk = link_mem[walk];
               if (walk == 0) begin
                  expected_beats.push_back(make_beat(ST_BEYOND, '0, '0, 1'b1));
               end else begin
                  link_mem[0]    = link_mem[cur];
                  value_mem[cur] = val;
                  link_mem[cur]  = link_mem[walk];
                  link_mem[walk] = cur;
                  expected_beats.push_back(make_beat(ST_OK, '0, cur, 1'b1));
               end
            end
         end
         MODE_DELETE: begin
            if (link_mem[LIST_HEAD] == 0) begin
               expected_beats.push_back(make_beat(ST_EMPTY, '0, '0, 1'b1));
            end else begin
               walk = SLOT_W'(LIST_HEAD);
               for (int k = 1; k < steps && walk != 0; k++)
                  walk = link_mem[walk];
               cur = (walk == 0) ? '0 : link_mem[walk];
               if (cur == 0) begin
                  expected_beats.push_back(make_beat(ST_BEYOND, '0, '0, 1'b1));
               end else begin
                  link_mem[walk] = link_mem[cur];
                  link_mem[cur]  = link_mem[0];
                  link_mem[0]    = cur;
                  expected_beats.push_back(make_beat(ST_OK, '0, cur, 1'b1));
               end
            end
         end
         MODE_DUMP: begin
            cur = link_mem[LIST_HEAD];
            if (cur == 0) begin
               expected_beats.push_back(make_beat(ST_EMPTY, '0, '0, 1'b1));
            end else begin
               n = 0;
               while (cur != 0 && n < MAX_RESULTS) begin
                  nxt = link_mem[cur];
                  expected_beats.push_back(make_beat(ST_OK, value_mem[cur], cur,
                                                     nxt == 0 || n + 1 == MAX_RESULTS));
                  n++;
                  cur = nxt;
               end
            end
         end
         default: ;
      endcase
   endtask

   // results of older commands first, then the command taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         reset_store();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat, slot", rsp_slot, '0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_value_res !== want.value)
                  report_mismatch("value", rsp_value_res, want.value);
               if (rsp_slot !== want.slot)
                  report_mismatch("slot", rsp_slot, want.slot);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            apply_list_command(req_mode, req_position, req_value);
      end
      pending_beats = expected_beats.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives list commands into the array linked list engine with random gaps
// and leaves all result checking to the checker instantiated beside it.
// ----------------------------------------------------------------------------
module testbench;
   import alle_pkg::*;

   localparam int                CYCLE_LIMIT     = 200000;
   localparam int                RANDOM_COMMANDS = 300;
   localparam int                LIST_CAPACITY   = 14;
   localparam int                SETTLE_CYCLES   = 40;
   localparam int                DRAIN_INTERVAL  = 75;
   localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       start         = 1'b0;
   logic [MODE_W-1:0]          req_mode      = '0;
   logic [POS_W-1:0]           req_position  = '0;
   logic signed [VALUE_W-1:0]  req_value     = '0;
   logic                       busy;
   logic                       rsp_strobe;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [VALUE_W-1:0]  rsp_value_res;
   logic [SLOT_W-1:0]          rsp_slot;
   logic                       rsp_last;

   int mismatch_count;
   int pending_beats;
   int cycle_count   = 0;
   int list_length   = 0;   // rough element count, used only to aim positions
   int no_gap_left   = 0;   // commands left in a back-to-back burst

   always #4 clock = ~clock;

   array_linked_list_engine dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value_res (rsp_value_res),
      .rsp_slot      (rsp_slot),
      .rsp_last      (rsp_last)
   );

   list_engine_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_value_res  (rsp_value_res),
      .rsp_slot       (rsp_slot),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats)
   );

   // Stop a hung run: the engine never drops busy or a beat never shows up.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Send one command beat. Called at a falling edge with nothing assigned
   // yet in that step; returns at the falling edge after the accepting edge,
   // with start still high so a back-to-back command can follow directly.
   task issue_command(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                      input logic signed [VALUE_W-1:0] val);
      int gap;
      int eff_pos;
      if (no_gap_left > 0) begin
         gap = 0;
         no_gap_left--;
      end else begin
         gap = $urandom_range(0, 7);
         if ($urandom_range(0, 15) == 0)
            no_gap_left = $urandom_range(5, 20);
      end
      // idle the request side for the drawn number of cycles
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      // hold the beat until an edge sees busy low
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
      // track the length so random positions land mostly inside the list
      eff_pos = (pos == 0) ? 1 : int'(pos);
      if (mode == MODE_INSERT && list_length < LIST_CAPACITY && eff_pos <= list_length + 1)
         list_length++;
      else if (mode == MODE_DELETE && list_length > 0 && eff_pos <= list_length)
         list_length--;
   endtask

   // Drop start and hold off until every expected beat has come back.
   task wait_for_results;
      start <= 1'b0;
      do @(negedge clock); while (pending_beats != 0);
   endtask

   initial begin
      logic [MODE_W-1:0]          mode;
      logic [POS_W-1:0]           pos;
      logic signed [VALUE_W-1:0]  val;
      int                         issued;
      int                         pick;
      bit                         grow;

      // hold reset, then release it on a falling edge
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      issue_command(MODE_DUMP, 4'd0, '0);                  // dump of an empty list
      issue_command(MODE_DELETE, 4'd1, '0);                // delete from an empty list
      issue_command(MODE_INSERT, 4'd0, 32'sh7fffffff);     // position 0 acts as 1
      issue_command(MODE_INSERT, 4'd1, 32'sh80000000);     // new head
      issue_command(MODE_INSERT, 4'd5, 32'shffffffff);     // insert past the end
      issue_command(MODE_INSERT, 4'd3, 32'sh00000000);     // append at the tail
      issue_command(MODE_DELETE, 4'd15, '0);               // delete past the end
      issue_command(MODE_DELETE, 4'd0, '0);                // delete the head
      issue_command(MODE_UNUSED, 4'd15, 32'shffffffff);    // ignored, no beat
      issue_command(MODE_DUMP, 4'd15, '0);
      // fill every free slot, alternating tail and random positions
      while (list_length < LIST_CAPACITY) begin
         if (list_length % 2 == 0)
            pos = POS_W'(list_length + 1);
         else
            pos = POS_W'($urandom_range(1, list_length + 1));
         issue_command(MODE_INSERT, pos, $urandom());
      end
      issue_command(MODE_INSERT, 4'd15, $urandom());       // full wins over past-end
      issue_command(MODE_INSERT, 4'd1, $urandom());        // full store
      issue_command(MODE_DUMP, 4'd0, '0);                  // longest dump
      issue_command(MODE_DELETE, 4'd14, '0);               // delete the tail of a full list
      wait_for_results();

      // ---- random part ----
      // Swing the list between empty and full so the walk reaches every depth;
      // positions mostly fall within the list, the rest anywhere.
      issued = 0;
      grow   = 1'b1;
      while (issued < RANDOM_COMMANDS) begin
         if (grow && list_length >= LIST_CAPACITY)
            grow = 1'b0;
         else if (!grow && list_length == 0)
            grow = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            mode = MODE_UNUSED;
         else if (pick < 13)
            mode = MODE_DUMP;
         else if (pick < (grow ? 73 : 33))
            mode = MODE_INSERT;
         else
            mode = MODE_DELETE;
         if ($urandom_range(0, 9) < 8)
            pos = POS_W'($urandom_range(0, list_length + 1));
         else
            pos = POS_W'($urandom_range(0, 15));
         val = $urandom();
         issue_command(mode, pos, val);
         if (mode != MODE_UNUSED) begin
            issued++;
            // pause now and then until the engine has answered everything
            if (issued % DRAIN_INTERVAL == 0)
               wait_for_results();
         end
      end

      // ---- wind down ----
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
